// File: rtl/ciir_pkg.sv
`timescale 1ns / 1ps

package ciir_pkg;

    // Filter geometry
    localparam int SECTIONS = 4;
    localparam int TAPS     = 3;
    localparam int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int TAP_W    = $clog2(TAPS);

    // Number formats
    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int DELAY_W  = 40;
    localparam int ACC_W    = 48;
    localparam int FRAC_W   = 28;
    localparam int DFRAC_W  = 8;

    // Field widths of a request
    localparam int OP_W      = 2;
    localparam int SECTION_W = 4;
    localparam int TAPF_W    = 4;

    // Request op codes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_FILTER = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Coefficient kinds
    localparam logic KIND_A = 1'b0;
    localparam logic KIND_B = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_ACC,
        ST_W0,
        ST_Y,
        ST_DONE
    } state_t;

    // Controls from the sequencer to the datapath
    typedef struct packed {
        logic             idle;
        logic             mul_lo;
        logic             mul_hi;
        logic             acc_en;
        logic             acc_clr;
        logic             acc_sub;
        logic             w0_wr;
        logic             y_wr;
        logic             out_wr;
        logic             phase;
        logic [TAP_W-1:0] tap;
        logic [SEC_W-1:0] sec;
    } ctrl_t;

endpackage

// File: rtl/ciir_if.sv
`timescale 1ns / 1ps

// Request channel: loads, samples and clears
interface ciir_cmd_if
    import ciir_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            op;
    logic [SECTION_W-1:0]       section;
    logic                       kind;
    logic [TAPF_W-1:0]          tap;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, op, section, kind, tap, coef_value, sample, input ready);
    modport sink   (input valid, op, section, kind, tap, coef_value, sample, output ready);
endinterface

// Result channel: one filtered sample per sample request
interface ciir_res_if
    import ciir_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       saturated;

    modport source (output valid, filtered, saturated, input ready);
    modport sink   (input valid, filtered, saturated, output ready);
endinterface

// File: rtl/ciir_mac.sv
`timescale 1ns / 1ps

module ciir_mac
    import ciir_pkg::*;
(
    input  logic                      clk,
    input  ctrl_t                     ctrl,
    input  logic signed [COEF_W-1:0]  coef,
    input  logic signed [DELAY_W-1:0] w,
    output logic signed [DELAY_W-1:0] sat_val,
    output logic                      sat_hit
);

    localparam int MB_W   = DELAY_W - 20 + 1;
    localparam int PROD_W = COEF_W + MB_W;
    localparam int FULL_W = PROD_W + 20;
    localparam int TERM_W = FULL_W - FRAC_W;

    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] lo_reg;
    logic signed [PROD_W-1:0] hi_reg;
    logic signed [FULL_W-1:0] full;
    logic signed [TERM_W-1:0] term;
    logic signed [ACC_W-1:0]  term_ext;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // Shared multiplier: low 20 bits of w unsigned, then the upper part signed
    assign mul_b = ctrl.mul_hi ? $signed({w[DELAY_W-1], w[DELAY_W-1:20]})
                               : $signed({1'b0, w[19:0]});
    assign prod  = coef * mul_b;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_lo)
        begin
            lo_reg <= prod;
        end
        if (ctrl.mul_hi)
        begin
            hi_reg <= prod;
        end
    end

    // Exact product, floor shift by 28, then add to or subtract from the accumulator
    assign full     = ($signed({{20{hi_reg[PROD_W-1]}}, hi_reg}) <<< 20)
                    + $signed({{20{lo_reg[PROD_W-1]}}, lo_reg});
    assign term     = full[FULL_W-1:FRAC_W];
    assign term_ext = $signed({{(ACC_W-TERM_W){term[TERM_W-1]}}, term});
    assign base     = ctrl.acc_clr ? '0 : acc_reg;
    assign acc_next = ctrl.acc_sub ? base - term_ext : base + term_ext;

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    // Clip to the delay format
    always_comb
    begin
        sat_hit = !((&acc_reg[ACC_W-1:DELAY_W-1]) || !(|acc_reg[ACC_W-1:DELAY_W-1]));
        if (!sat_hit)
        begin
            sat_val = acc_reg[DELAY_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            sat_val = {1'b1, {(DELAY_W-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(DELAY_W-1){1'b1}}};
        end
    end

endmodule

// File: rtl/ciir_seq.sv
`timescale 1ns / 1ps

module ciir_seq
    import ciir_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  out_free,
    output ctrl_t ctrl
);

    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAPS - 1);
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);

    state_t           state_reg, state_next;
    logic [TAP_W-1:0] tap_reg, tap_next;
    logic [SEC_W-1:0] sec_reg, sec_next;
    logic             phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
            sec_reg   <= '0;
            phase_reg <= KIND_A;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            sec_reg   <= sec_next;
            phase_reg <= phase_next;
        end
    end

    // Next state and counters
    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        sec_next   = sec_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LO;
                    tap_next   = '0;
                    sec_next   = '0;
                    phase_next = KIND_A;
                end
            end
            ST_LO:
            begin
                state_next = ST_HI;
            end
            ST_HI:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (tap_reg == TAP_LAST)
                begin
                    state_next = (phase_reg == KIND_B) ? ST_Y : ST_W0;
                end
                else
                begin
                    state_next = ST_LO;
                    tap_next   = tap_reg + 1'b1;
                end
            end
            ST_W0:
            begin
                state_next = ST_LO;
                tap_next   = '0;
                phase_next = KIND_B;
            end
            ST_Y:
            begin
                tap_next   = '0;
                phase_next = KIND_A;
                if (sec_reg == SEC_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LO;
                    sec_next   = sec_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath controls
    always_comb
    begin
        ctrl         = '0;
        ctrl.phase   = phase_reg;
        ctrl.tap     = tap_reg;
        ctrl.sec     = sec_reg;
        unique case (state_reg)
            ST_IDLE: ctrl.idle   = 1'b1;
            ST_LO:   ctrl.mul_lo = 1'b1;
            ST_HI:   ctrl.mul_hi = 1'b1;
            ST_ACC:
            begin
                ctrl.acc_en  = 1'b1;
                ctrl.acc_clr = (tap_reg == '0);
                ctrl.acc_sub = (phase_reg == KIND_A) && (tap_reg != '0);
            end
            ST_W0:   ctrl.w0_wr  = 1'b1;
            ST_Y:    ctrl.y_wr   = 1'b1;
            ST_DONE: ctrl.out_wr = out_free;
            default: ctrl.idle   = 1'b0;
        endcase
    end

endmodule

// File: rtl/cascaded_iir_filter_unit.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload                                  | Moves when
// cmd     | in  | op, section, kind, tap, coef_value, sample | valid && ready
// res     | out | filtered, saturated                      | valid && ready
//
// A sample request runs through every tap of both kinds in each section:
// each product uses the one 32x21 multiplier twice plus an accumulate.
// Loads, clears and op 3 do not leave the idle state; ready is high only while idle.
// Reset clears coefficients, delay values and the output valid flag.
// A result waiting in the output register holds the next result back.

module cascaded_iir_filter_unit
    import ciir_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ciir_cmd_if.sink  cmd,
    ciir_res_if.source res
);

    ctrl_t                      ctrl;
    logic                       accept;
    logic                       out_free;
    logic signed [COEF_W-1:0]   coef_reg  [SECTIONS][2][TAPS];
    logic signed [DELAY_W-1:0]  delay_reg [SECTIONS][TAPS];
    logic signed [DELAY_W-1:0]  x_reg;
    logic                       flag_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] filt_reg;
    logic                       sat_out_reg;
    logic signed [COEF_W-1:0]   coef_op;
    logic signed [DELAY_W-1:0]  w_op;
    logic signed [DELAY_W-1:0]  sat_val;
    logic                       sat_hit;
    logic                       load_ok;
    logic                       final_clip;
    logic signed [SAMPLE_W-1:0] final_val;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = ctrl.idle;
    assign out_free  = !out_valid_reg || res.ready;
    assign load_ok   = ({1'b0, cmd.section} < (SECTION_W+1)'(SECTIONS))
                    && ({1'b0, cmd.tap} < (TAPF_W+1)'(TAPS));

    ciir_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && (cmd.op == OP_FILTER)),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // Operand selection for the shared multiplier
    assign coef_op = coef_reg[ctrl.sec][ctrl.phase][ctrl.tap];
    assign w_op    = ((ctrl.phase == KIND_A) && (ctrl.tap == '0)) ? x_reg
                                                                  : delay_reg[ctrl.sec][ctrl.tap];

    ciir_mac u_mac (
        .clk     (clk),
        .ctrl    (ctrl),
        .coef    (coef_op),
        .w       (w_op),
        .sat_val (sat_val),
        .sat_hit (sat_hit)
    );

    // Coefficient store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SECTIONS; s++)
            begin
                for (int k = 0; k < TAPS; k++)
                begin
                    coef_reg[s][0][k] <= '0;
                    coef_reg[s][1][k] <= '0;
                end
            end
        end
        else if (accept && (cmd.op == OP_LOAD) && load_ok)
        begin
            coef_reg[cmd.section[SEC_W-1:0]][cmd.kind][cmd.tap[TAP_W-1:0]] <= cmd.coef_value;
        end
    end

    // Delay store: clear, new w0, then shift at the end of a section
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SECTIONS; s++)
            begin
                for (int k = 0; k < TAPS; k++)
                begin
                    delay_reg[s][k] <= '0;
                end
            end
        end
        else if (accept && (cmd.op == OP_CLEAR))
        begin
            for (int s = 0; s < SECTIONS; s++)
            begin
                for (int k = 0; k < TAPS; k++)
                begin
                    delay_reg[s][k] <= '0;
                end
            end
        end
        else if (ctrl.w0_wr)
        begin
            delay_reg[ctrl.sec][0] <= sat_val;
        end
        else if (ctrl.y_wr)
        begin
            for (int k = 1; k < TAPS; k++)
            begin
                delay_reg[ctrl.sec][k] <= delay_reg[ctrl.sec][k-1];
            end
        end
    end

    // Section input and clip flag
    always_ff @(posedge clk)
    begin
        if (accept && (cmd.op == OP_FILTER))
        begin
            x_reg    <= $signed({{(DELAY_W-SAMPLE_W-DFRAC_W){cmd.sample[SAMPLE_W-1]}},
                                 cmd.sample, {DFRAC_W{1'b0}}});
            flag_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.y_wr)
            begin
                x_reg <= sat_val;
            end
            if ((ctrl.w0_wr || ctrl.y_wr) && sat_hit)
            begin
                flag_reg <= 1'b1;
            end
        end
    end

    // Final scaling to the sample format
    always_comb
    begin
        final_clip = !((&x_reg[DELAY_W-1:SAMPLE_W+DFRAC_W-1])
                    || !(|x_reg[DELAY_W-1:SAMPLE_W+DFRAC_W-1]));
        if (!final_clip)
        begin
            final_val = x_reg[SAMPLE_W+DFRAC_W-1:DFRAC_W];
        end
        else if (x_reg[DELAY_W-1])
        begin
            final_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            final_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_wr)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_wr)
        begin
            filt_reg    <= final_val;
            sat_out_reg <= flag_reg || final_clip;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.filtered  = filt_reg;
    assign res.saturated = sat_out_reg;

endmodule
